// File: rtl/core/tea_block_cipher_assert.svh
// Assertion macros shared by the TEA checker
`ifndef TEA_BLOCK_CIPHER_ASSERT_SVH
`define TEA_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TEA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tea assertion failed");

// next-cycle implication, disabled in reset
`define TEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tea assertion failed");

`endif

// File: rtl/core/tea_pkg.sv
// Types and constants for the TEA block cipher
package tea_pkg;

  localparam int WORD_W    = 32;
  localparam int ROUNDS    = 32;
  localparam int NUM_CELLS = 2 * ROUNDS;   // one cell per half-round
  localparam int CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;
  localparam logic [63:0] SUM_DEC_FULL = 64'(ROUNDS) * 64'(TEA_DELTA);
  localparam logic [WORD_W-1:0] SUM_DEC_INIT = SUM_DEC_FULL[WORD_W-1:0];

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  // state that walks down the cell row with each block
  typedef struct packed {
    logic              cmd;
    logic              half;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } tea_data_t;

  typedef struct packed {
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
  } tea_block_t;

endpackage

// File: rtl/core/tea_if.sv
// Stream interfaces for the TEA input and result channels
interface tea_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] block_word0;
  logic [31:0] block_word1;

  modport source (output valid, cmd, block_word0, block_word1, input ready);
  modport sink   (input valid, cmd, block_word0, block_word1, output ready);
endinterface

interface tea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word0;
  logic [31:0] out_word1;

  modport source (output valid, out_word0, out_word1, input ready);
  modport sink   (input valid, out_word0, out_word1, output ready);
endinterface

// File: rtl/core/tea_cell.sv
// One TEA half-round cell of the pipeline row
module tea_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  tea_pkg::tea_data_t data_in,
  input  tea_pkg::tea_key_t  key,
  output logic              valid,
  output tea_pkg::tea_data_t data
);
  import tea_pkg::*;

  logic              upd_y;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] ka;
  logic [WORD_W-1:0] kb;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] res;
  logic [WORD_W-1:0] sum_next;
  tea_data_t         data_next;

  // encrypt: first half updates y, decrypt: first half updates z
  assign upd_y = (data_in.half == data_in.cmd);

  always_comb begin
    src = upd_y ? data_in.z : data_in.y;
    dst = upd_y ? data_in.y : data_in.z;
    ka  = upd_y ? key.k0 : key.k2;
    kb  = upd_y ? key.k1 : key.k3;
    mix = ((src << 4) + ka) ^ (src + data_in.sum) ^ ((src >> 5) + kb);
    res = (data_in.cmd == CMD_DECRYPT) ? dst - mix : dst + mix;
    // running sum steps once per full round
    if (data_in.half) begin
      sum_next = (data_in.cmd == CMD_DECRYPT) ? data_in.sum - TEA_DELTA
                                              : data_in.sum + TEA_DELTA;
    end else begin
      sum_next = data_in.sum;
    end
    data_next      = data_in;
    data_next.half = ~data_in.half;
    data_next.sum  = sum_next;
    data_next.y    = upd_y ? res : data_in.y;
    data_next.z    = upd_y ? data_in.z : res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

// File: rtl/core/tea_skid.sv
// Output register with one skid word behind it
module tea_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tea_pkg::tea_block_t push_data,
  output logic               full,
  tea_out_if.source          dout
);
  import tea_pkg::*;

  logic       out_valid;
  tea_block_t out_data;
  logic       skid_valid;
  tea_block_t skid_data;
  logic       hold;

  assign hold = out_valid & ~dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (hold) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (hold) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end

  assign full           = skid_valid;
  assign dout.valid     = out_valid;
  assign dout.out_word0 = out_data.w0;
  assign dout.out_word1 = out_data.w1;

endmodule

// File: rtl/core/tea_block_cipher.sv
// TEA block cipher, top level: key registers, half-round cell row, output buffer
//
//  channel   dir  handshake      word
//  blk_in    in   valid/ready    cmd, block_word0, block_word1
//  blk_out   out  valid/ready    out_word0, out_word1
//  cfg       in   cfg_we         cfg_index, cfg_data (key words 0..3)
//
// One block enters per cycle while the skid word is free; the path is 64 half-round
// cells, one per register stage, then the output register.
// The whole cell row advances together; it stalls only while the skid word
// behind the output register is occupied, so blk_in.ready comes from a register.
// Reset clears the valid bits and the keys; no clearing pass.
module tea_block_cipher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]    cfg_data,
  tea_in_if.sink                        blk_in,
  tea_out_if.source                     blk_out
);
  import tea_pkg::*;

  tea_key_t   key;
  logic       en;
  logic       skid_full;
  logic       cell_valid [NUM_CELLS+1];
  tea_data_t  cell_data  [NUM_CELLS+1];
  tea_block_t last_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0: key.k0 <= cfg_data;
        REG_KEY1: key.k1 <= cfg_data;
        REG_KEY2: key.k2 <= cfg_data;
        REG_KEY3: key.k3 <= cfg_data;
      endcase
    end
  end

  assign en           = ~skid_full;
  assign blk_in.ready = en;

  always_comb begin
    cell_valid[0]     = blk_in.valid;
    cell_data[0].cmd  = blk_in.cmd;
    cell_data[0].half = 1'b0;
    cell_data[0].sum  = (blk_in.cmd == CMD_DECRYPT) ? SUM_DEC_INIT : TEA_DELTA;
    cell_data[0].y    = blk_in.block_word0;
    cell_data[0].z    = blk_in.block_word1;
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    tea_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (cell_valid[i]),
      .data_in  (cell_data[i]),
      .key      (key),
      .valid    (cell_valid[i+1]),
      .data     (cell_data[i+1])
    );
  end

  assign last_block.w0 = cell_data[NUM_CELLS].y;
  assign last_block.w1 = cell_data[NUM_CELLS].z;

  tea_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (en & cell_valid[NUM_CELLS]),
    .push_data (last_block),
    .full      (skid_full),
    .dout      (blk_out)
  );

endmodule

// File: rtl/core/tea_checker.sv
// Port-level checks for the TEA block cipher, bound to the top level
`include "tea_block_cipher_assert.svh"

module tea_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word0,
  input logic [31:0] out_word1
);

  // a held result word keeps its value
  `TEA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word0) && $stable(out_word1))
  // input is only refused while a result is waiting
  `TEA_ASSERT_NOW(a_stall_has_result, !in_ready, out_valid)
  // a taken result frees the skid word at once
  `TEA_ASSERT_NEXT(a_stall_clears, !in_ready && out_ready, in_ready)
  // nothing can be out, and nothing is refused, straight after reset
  `TEA_ASSERT_NOW(a_after_reset, $past(rst), in_ready && !out_valid)

endmodule

bind tea_block_cipher tea_checker u_tea_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (blk_in.ready),
  .out_valid (blk_out.valid),
  .out_ready (blk_out.ready),
  .out_word0 (blk_out.out_word0),
  .out_word1 (blk_out.out_word1)
);

// File: tb/tea_block_cipher_tb.sv
// Self-checking testbench for the TEA block cipher: directed table, then random blocks
`timescale 1ns / 1ps

module tea_block_cipher_tb;
  import tea_pkg::*;

  localparam int IDLE_LIMIT = 2000;   // cycles with no word moving on either channel
  localparam int DRAIN_WAIT = 70;     // pipeline latency plus margin
  localparam int PHASE_ITEMS = 80;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic              has_lit;
    logic [WORD_W-1:0] lit0;
    logic [WORD_W-1:0] lit1;
  } dir_row_t;

  localparam int NUM_DIR = 14;

  // all rows run under the zero key left by reset
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h41EA_3A0A, 32'h94BA_A940},
    '{CMD_DECRYPT, 32'h41EA_3A0A, 32'h94BA_A940, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{CMD_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
    '{CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0, 32'h0},
    '{CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0},
    '{CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, 1'b0, 32'h0, 32'h0},
    '{CMD_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567, 1'b0, 32'h0, 32'h0}
  };

  localparam logic [CFG_IDX_W-1:0] KEY_REG [4] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};

  localparam logic [WORD_W-1:0] EDGE_KEYS [3][4] = '{
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  tea_in_if  in_bus ();
  tea_out_if out_bus ();

  tea_block_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk_in    (in_bus.sink),
    .blk_out   (out_bus.source)
  );

  always #5 clk = ~clk;

  logic [WORD_W-1:0] key_copy [4] = '{default: '0};
  tea_block_t        ciphered_blocks [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  logic [7:0]        stall_mask = 8'hFF;
  logic [2:0]        stall_pos = '0;
  tea_block_t        oldest;

  task automatic report_mismatch(input string what);
    $display("tea_block_cipher_tb: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] v,
                                                  input logic [WORD_W-1:0] sum,
                                                  input logic [WORD_W-1:0] ka,
                                                  input logic [WORD_W-1:0] kb);
    return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

  function automatic tea_block_t tea_transform(input logic cmd,
                                               input logic [WORD_W-1:0] w0,
                                               input logic [WORD_W-1:0] w1);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] sum;
    tea_block_t        res;
    y = w0;
    z = w1;
    if (cmd == CMD_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        sum = sum + TEA_DELTA;
        y = y + round_mix(z, sum, key_copy[0], key_copy[1]);
        z = z + round_mix(y, sum, key_copy[2], key_copy[3]);
      end
    end else begin
      sum = 32'(ROUNDS) * TEA_DELTA;   // wraps mod 2^32
      for (int r = 0; r < ROUNDS; r++) begin
        z = z - round_mix(y, sum, key_copy[2], key_copy[3]);
        y = y - round_mix(z, sum, key_copy[0], key_copy[1]);
        sum = sum - TEA_DELTA;
      end
    end
    res.w0 = y;
    res.w1 = z;
    return res;
  endfunction

  // holds valid high until the word is taken; the caller lowers it
  task automatic send_block(input logic cmd, input logic [WORD_W-1:0] w0,
                            input logic [WORD_W-1:0] w1, input tea_block_t due);
    in_bus.valid       <= 1'b1;
    in_bus.cmd         <= cmd;
    in_bus.block_word0 <= w0;
    in_bus.block_word1 <= w1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    ciphered_blocks.push_back(due);
  endtask

  task automatic set_key(input logic [WORD_W-1:0] words [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= KEY_REG[i];
      cfg_data  <= words[i];
      @(posedge clk);
      key_copy[i] = words[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (ciphered_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int                left;
    int                burst;
    int                gap;
    logic              cmd;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    tea_block_t        prev;
    logic              prev_cmd;
    logic              have_prev;
    left = count;
    have_prev = 1'b0;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && left > 0; i++) begin
        if (have_prev && $urandom_range(0, 3) == 0) begin
          // feed the last result back the other way round
          cmd = ~prev_cmd;
          w0  = prev.w0;
          w1  = prev.w1;
        end else begin
          cmd = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 7))
            0:       w0 = '0;
            1:       w0 = '1;
            default: w0 = $urandom;
          endcase
          case ($urandom_range(0, 7))
            0:       w1 = '0;
            1:       w1 = '1;
            default: w1 = $urandom;
          endcase
        end
        prev      = tea_transform(cmd, w0, w1);
        prev_cmd  = cmd;
        have_prev = 1'b1;
        send_block(cmd, w0, w1, prev);
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_bus.valid <= 1'b0;
  endtask

  // receiver: ready follows an 8-bit stall mask, stepped bit by bit, re-drawn now and then
  always @(posedge clk) begin
    stall_pos     <= stall_pos + 3'd1;
    out_bus.ready <= stall_mask[stall_pos];
    if (stall_pos == 3'd7 && $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_mask <= 8'hFF;
        1:       stall_mask <= 8'h01 << $urandom_range(0, 7);
        default: stall_mask <= 8'($urandom) | 8'h80;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (ciphered_blocks.size() == 0) begin
        report_mismatch("result word with no block pending");
      end else begin
        oldest = ciphered_blocks.pop_front();
        if (out_bus.out_word0 !== oldest.w0)
          report_mismatch($sformatf("out_word0 %h, want %h", out_bus.out_word0, oldest.w0));
        if (out_bus.out_word1 !== oldest.w1)
          report_mismatch($sformatf("out_word1 %h, want %h", out_bus.out_word1, oldest.w1));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tea_block_cipher_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [WORD_W-1:0] rand_key [4];
    tea_block_t        due;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_KEY0;
    cfg_data           <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.cmd         <= CMD_ENCRYPT;
    in_bus.block_word0 <= '0;
    in_bus.block_word1 <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed rows go back to back, no sender gaps
    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].has_lit) begin
        due.w0 = DIR_ROWS[i].lit0;
        due.w1 = DIR_ROWS[i].lit1;
      end else begin
        due = tea_transform(DIR_ROWS[i].cmd, DIR_ROWS[i].w0, DIR_ROWS[i].w1);
      end
      send_block(DIR_ROWS[i].cmd, DIR_ROWS[i].w0, DIR_ROWS[i].w1, due);
    end
    in_bus.valid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      if (p < 3) begin
        set_key(EDGE_KEYS[p]);
      end else begin
        foreach (rand_key[k]) rand_key[k] = $urandom;
        set_key(rand_key);
      end
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("tea_block_cipher_tb: done, clean");
    else
      $display("tea_block_cipher_tb: done, errors");
    $finish;
  end

endmodule
